// ===== rtl/lje_pkg.sv =====
// Package for the Lennard-Jones energy engine.
// Holds payload structs, operation codes, register indexes, controller states and commands.
// No dependencies.
package lje_pkg;

  localparam int unsigned POS_W = 24;
  localparam int unsigned CFG_W = 23;
  localparam int unsigned CNT_W = 9;
  localparam int unsigned OUT_W = 48;
  localparam int unsigned TERM_W = 47;
  localparam logic [TERM_W-1:0] TERM_MAX = '1;

  localparam int unsigned DEF_MAX_PARTICLES = 256;
  localparam int unsigned DEF_FRACTION_BITS = 16;

  localparam logic [CFG_W-1:0] BOX_RESET = 23'd655360;
  localparam logic [CFG_W-1:0] CUT_RESET = 23'd409600;
  localparam logic [CNT_W-1:0] COUNT_RESET = 9'd256;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_QUERY = 2'd1,
    OP_TOTAL = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    REG_BOX_LENGTH = 2'd0,
    REG_CUTOFF_SQUARED = 2'd1,
    REG_PARTICLE_COUNT = 2'd2
  } reg_e;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] particle_index;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
  } in_item_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] energy;
    logic signed [OUT_W-1:0] virial;
    logic saturated;
  } out_item_t;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
  } pos_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_REFRD,
    S_REFLD,
    S_NEXT,
    S_DIFF,
    S_SQ,
    S_SUM,
    S_CHK,
    S_DIV,
    S_MINIT,
    S_MSTEP,
    S_MFIN,
    S_ACC,
    S_SCALE,
    S_DONE
  } state_e;

  typedef struct packed {
    logic ld_ref_in;
    logic ld_ref_mem;
    logic clr_acc;
    logic diff;
    logic square;
    logic sum;
    logic pair_begin;
    logic div_init;
    logic div_step;
    logic mul_init;
    logic mul_step;
    logic mul_fin;
    logic [1:0] mul_phase;
    logic accumulate;
    logic total;
    logic scale;
  } cmd_t;

  typedef struct packed {
    logic in_cut;
    logic szero;
  } status_t;

endpackage

// ===== rtl/lje_store.sv =====
// Position store of the energy engine: one write port and one registered read port.
// Depends on lje_pkg.
module lje_store
  import lje_pkg::*;
#(
  parameter int unsigned DEPTH = DEF_MAX_PARTICLES,
  parameter int unsigned AW = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  pos_t          wr_data_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output pos_t          rd_data_o
);

  pos_t mem_q [DEPTH];
  pos_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/lje_datapath.sv =====
// Arithmetic datapath: minimum image, squared distance, serial divider,
// digit-serial multiplier, saturating accumulators and final scaling. Depends on lje_pkg.
module lje_datapath
  import lje_pkg::*;
#(
  parameter int unsigned FRACTION_BITS = DEF_FRACTION_BITS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmd_t                cmd_i,
  input  pos_t                in_pos_i,
  input  pos_t                mem_pos_i,
  input  logic [CFG_W-1:0]    box_i,
  input  logic [CFG_W-1:0]    cut_i,
  output status_t             status_o,
  output out_item_t           result_o
);

  localparam int unsigned F = FRACTION_BITS;
  localparam int unsigned MAGW = 25;
  localparam int unsigned SQW = 2 * MAGW;
  localparam int unsigned QW = SQW + 2;
  localparam int unsigned SW = QW - F;
  localparam int unsigned DNW = 2 * F + 1;
  localparam int unsigned OW = (DNW > 48) ? DNW : 48;
  localparam int unsigned MSTEPS = (OW + 7) / 8;
  localparam int unsigned BW = 8 * MSTEPS;
  localparam int unsigned PW = OW + BW;
  localparam int unsigned PPW = OW + 8;
  localparam int unsigned CAPB = (TERM_W + F < 64) ? TERM_W + F : 64;
  localparam logic signed [51:0] HI52 = 52'sh0_7FFF_FFFF_FFFF;
  localparam logic signed [51:0] LO52 = -52'sh0_8000_0000_0000;

  function automatic logic [MAGW-1:0] min_image(input logic signed [POS_W-1:0] a,
                                                input logic signed [POS_W-1:0] b,
                                                input logic [CFG_W-1:0] box);
    logic signed [26:0] d;
    logic signed [26:0] bx;
    logic signed [26:0] r;
    logic [26:0] m;
    d = 27'(a) - 27'(b);
    bx = $signed({4'b0, box});
    if ((d <<< 1) > bx) begin
      r = d - bx;
    end else if ((d <<< 1) < -bx) begin
      r = d + bx;
    end else begin
      r = d;
    end
    m = (r < 0) ? 27'(-r) : 27'(r);
    return m[MAGW-1:0];
  endfunction

  function automatic logic [48:0] clamp(input logic signed [51:0] v);
    logic [48:0] r;
    if (v > HI52) begin
      r = {1'b1, 48'sh7FFF_FFFF_FFFF};
    end else if (v < LO52) begin
      r = {1'b1, 48'sh8000_0000_0000};
    end else begin
      r = {1'b0, v[47:0]};
    end
    return r;
  endfunction

  pos_t ref_q;
  logic [MAGW-1:0] mx_q, my_q, mz_q;
  logic [SQW-1:0] sx_q, sy_q, sz_q;
  logic [QW-1:0] q_q;
  logic [SW-1:0] rem_q;
  logic [DNW-1:0] quo_q, dvd_q;
  logic [OW-1:0] inv_q, ma_q;
  logic [BW-1:0] mb_q;
  logic [PW-1:0] prod_q;
  logic [TERM_W-1:0] inv2_q, inv3_q, inv6_q;
  logic cap_q;
  logic signed [OUT_W-1:0] esum_q, wsum_q;
  logic sat_q;
  out_item_t res_q;

  logic [SW-1:0] s;
  logic [SW:0] trial, tdiff;
  logic [OW-1:0] inv_val;
  logic inv_over;
  logic [PPW-1:0] pp;
  logic prod_cap;
  logic [TERM_W-1:0] prod_res;
  logic signed [51:0] eterm, wterm;
  logic [48:0] enext, wnext, escl, wscl;

  assign s = q_q[QW-1:F];
  assign status_o.in_cut = q_q < QW'({cut_i, {F{1'b0}}});
  assign status_o.szero = (s == '0);

  assign trial = {rem_q, dvd_q[DNW-1]};
  assign tdiff = trial - {1'b0, s};
  assign inv_over = OW'(quo_q) > OW'(TERM_MAX);
  assign inv_val = inv_over ? OW'(TERM_MAX) : OW'(quo_q);
  assign pp = PPW'(ma_q) * PPW'(mb_q[BW-1 -: 8]);
  assign prod_cap = |prod_q[PW-1:CAPB];
  assign prod_res = prod_q[F+TERM_W-1:F];

  always_comb begin
    if (cap_q) begin
      eterm = 52'(TERM_MAX);
      wterm = 52'(TERM_MAX);
    end else begin
      eterm = $signed(52'(inv6_q)) - $signed(52'(inv3_q));
      wterm = $signed(52'(inv6_q)) - $signed(52'(inv3_q >> 1));
    end
  end

  assign enext = clamp(52'(esum_q) + eterm);
  assign wnext = clamp(52'(wsum_q) + wterm);
  assign escl = clamp($signed({{2{esum_q[OUT_W-1]}}, esum_q, 2'b0}));
  assign wscl = clamp($signed({wsum_q, 4'b0}));

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_ref_in) begin
      ref_q <= in_pos_i;
    end else if (cmd_i.ld_ref_mem) begin
      ref_q <= mem_pos_i;
    end
    if (cmd_i.diff) begin
      mx_q <= min_image(ref_q.x, mem_pos_i.x, box_i);
      my_q <= min_image(ref_q.y, mem_pos_i.y, box_i);
      mz_q <= min_image(ref_q.z, mem_pos_i.z, box_i);
    end
    if (cmd_i.square) begin
      sx_q <= SQW'(mx_q) * SQW'(mx_q);
      sy_q <= SQW'(my_q) * SQW'(my_q);
      sz_q <= SQW'(mz_q) * SQW'(mz_q);
    end
    if (cmd_i.sum) begin
      q_q <= QW'(sx_q) + QW'(sy_q) + QW'(sz_q);
    end
    if (cmd_i.div_init) begin
      rem_q <= '0;
      quo_q <= '0;
      dvd_q <= {1'b1, {(2 * F){1'b0}}};
    end else if (cmd_i.div_step) begin
      dvd_q <= dvd_q << 1;
      if (!tdiff[SW]) begin
        rem_q <= tdiff[SW-1:0];
        quo_q <= {quo_q[DNW-2:0], 1'b1};
      end else begin
        rem_q <= trial[SW-1:0];
        quo_q <= {quo_q[DNW-2:0], 1'b0};
      end
    end
    if (cmd_i.mul_init) begin
      prod_q <= '0;
      unique case (cmd_i.mul_phase)
        2'd0: begin
          inv_q <= inv_val;
          ma_q <= inv_val;
          mb_q <= BW'(inv_val);
        end
        2'd1: begin
          ma_q <= OW'(inv2_q);
          mb_q <= BW'(inv_q);
        end
        default: begin
          ma_q <= OW'(inv3_q);
          mb_q <= BW'(inv3_q);
        end
      endcase
    end else if (cmd_i.mul_step) begin
      prod_q <= (prod_q << 8) + PW'(pp);
      mb_q <= mb_q << 8;
    end
    if (cmd_i.mul_fin) begin
      unique case (cmd_i.mul_phase)
        2'd0: inv2_q <= prod_cap ? TERM_MAX : prod_res;
        2'd1: inv3_q <= prod_cap ? TERM_MAX : prod_res;
        default: inv6_q <= prod_cap ? TERM_MAX : prod_res;
      endcase
    end
    if (cmd_i.scale) begin
      res_q.energy <= escl[47:0];
      res_q.virial <= cmd_i.total ? wscl[47:0] : '0;
      res_q.saturated <= sat_q | escl[48] | (cmd_i.total & wscl[48]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= 1'b0;
      sat_q <= 1'b0;
      esum_q <= '0;
      wsum_q <= '0;
    end else begin
      if (cmd_i.pair_begin) begin
        cap_q <= status_o.szero;
      end else if (cmd_i.mul_init && cmd_i.mul_phase == 2'd0) begin
        cap_q <= cap_q | inv_over;
      end else if (cmd_i.mul_fin) begin
        cap_q <= cap_q | prod_cap;
      end
      if (cmd_i.clr_acc) begin
        sat_q <= 1'b0;
        esum_q <= '0;
        wsum_q <= '0;
      end else if (cmd_i.accumulate) begin
        esum_q <= enext[47:0];
        if (cmd_i.total) begin
          wsum_q <= wnext[47:0];
        end
        sat_q <= sat_q | cap_q | enext[48] | (cmd_i.total & wnext[48]);
      end
    end
  end

  assign result_o = res_q;

endmodule

// ===== rtl/lje_ctrl.sv =====
// Controller state machine: walks the pair loops and sequences the datapath.
// Depends on lje_pkg.
module lje_ctrl
  import lje_pkg::*;
#(
  parameter int unsigned MAX_PARTICLES = DEF_MAX_PARTICLES,
  parameter int unsigned FRACTION_BITS = DEF_FRACTION_BITS,
  parameter int unsigned CW = $clog2(MAX_PARTICLES + 1),
  parameter int unsigned AW = $clog2(MAX_PARTICLES)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic          total_i,
  input  logic [7:0]    excl_i,
  input  logic [CW-1:0] n_i,
  input  status_t       status_i,
  input  logic          out_free_i,
  output logic          idle_o,
  output logic          done_o,
  output cmd_t          cmd_o,
  output logic          rd_en_o,
  output logic [AW-1:0] rd_addr_o
);

  localparam int unsigned DNW = 2 * FRACTION_BITS + 1;
  localparam int unsigned OW = (DNW > 48) ? DNW : 48;
  localparam int unsigned MSTEPS = (OW + 7) / 8;
  localparam int unsigned TW = $clog2(DNW + 1);

  state_e state_q, state_d;
  logic [CW-1:0] i_q, i_d, j_q, j_d;
  logic [TW-1:0] cnt_q, cnt_d;
  logic [1:0] phase_q, phase_d;
  logic total_q, total_d;
  logic [7:0] excl_q, excl_d;
  logic j_end, skip, i_end;

  assign j_end = j_q >= n_i;
  assign skip = !total_q && (32'(j_q) == 32'(excl_q));
  assign i_end = (32'(i_q) + 32'd2) >= 32'(n_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          if (total_i) begin
            state_d = (n_i < CW'(2)) ? S_SCALE : S_REFRD;
          end else begin
            state_d = (n_i == '0) ? S_SCALE : S_NEXT;
          end
        end
      end
      S_REFRD: state_d = S_REFLD;
      S_REFLD: state_d = S_NEXT;
      S_NEXT: begin
        if (j_end) begin
          state_d = (!total_q || i_end) ? S_SCALE : S_REFRD;
        end else if (!skip) begin
          state_d = S_DIFF;
        end
      end
      S_DIFF: state_d = S_SQ;
      S_SQ: state_d = S_SUM;
      S_SUM: state_d = S_CHK;
      S_CHK: begin
        if (!status_i.in_cut) begin
          state_d = S_NEXT;
        end else if (status_i.szero) begin
          state_d = S_ACC;
        end else begin
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (cnt_q == TW'(DNW - 1)) begin
          state_d = S_MINIT;
        end
      end
      S_MINIT: state_d = S_MSTEP;
      S_MSTEP: begin
        if (cnt_q == TW'(MSTEPS - 1)) begin
          state_d = S_MFIN;
        end
      end
      S_MFIN: state_d = (phase_q == 2'd2) ? S_ACC : S_MINIT;
      S_ACC: state_d = S_NEXT;
      S_SCALE: state_d = S_DONE;
      S_DONE: begin
        if (out_free_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.total = total_q;
    cmd_o.mul_phase = phase_q;
    i_d = i_q;
    j_d = j_q;
    cnt_d = cnt_q;
    phase_d = phase_q;
    total_d = total_q;
    excl_d = excl_q;
    rd_en_o = 1'b0;
    rd_addr_o = j_q[AW-1:0];
    done_o = 1'b0;
    idle_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        idle_o = 1'b1;
        if (start_i) begin
          cmd_o.clr_acc = 1'b1;
          cmd_o.ld_ref_in = !total_i;
          total_d = total_i;
          excl_d = excl_i;
          i_d = '0;
          j_d = '0;
        end
      end
      S_REFRD: begin
        rd_en_o = 1'b1;
        rd_addr_o = i_q[AW-1:0];
        j_d = i_q + CW'(1);
      end
      S_REFLD: cmd_o.ld_ref_mem = 1'b1;
      S_NEXT: begin
        if (j_end) begin
          i_d = i_q + CW'(1);
        end else if (skip) begin
          j_d = j_q + CW'(1);
        end else begin
          rd_en_o = 1'b1;
        end
      end
      S_DIFF: cmd_o.diff = 1'b1;
      S_SQ: cmd_o.square = 1'b1;
      S_SUM: cmd_o.sum = 1'b1;
      S_CHK: begin
        cmd_o.pair_begin = 1'b1;
        cnt_d = '0;
        phase_d = 2'd0;
        if (!status_i.in_cut) begin
          j_d = j_q + CW'(1);
        end else if (!status_i.szero) begin
          cmd_o.div_init = 1'b1;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d = cnt_q + TW'(1);
      end
      S_MINIT: begin
        cmd_o.mul_init = 1'b1;
        cnt_d = '0;
      end
      S_MSTEP: begin
        cmd_o.mul_step = 1'b1;
        cnt_d = cnt_q + TW'(1);
      end
      S_MFIN: begin
        cmd_o.mul_fin = 1'b1;
        phase_d = phase_q + 2'd1;
      end
      S_ACC: begin
        cmd_o.accumulate = 1'b1;
        j_d = j_q + CW'(1);
      end
      S_SCALE: cmd_o.scale = 1'b1;
      S_DONE: done_o = out_free_i;
      default: idle_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      i_q <= '0;
      j_q <= '0;
      cnt_q <= '0;
      phase_q <= 2'd0;
      total_q <= 1'b0;
      excl_q <= '0;
    end else begin
      state_q <= state_d;
      i_q <= i_d;
      j_q <= j_d;
      cnt_q <= cnt_d;
      phase_q <= phase_d;
      total_q <= total_d;
      excl_q <= excl_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIFF) |-> $past(rd_en_o))
    else $error("Pair difference taken without a preceding store read.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIFF) |-> (j_q < n_i))
    else $error("Pair index beyond the particles in use.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MFIN) |-> (phase_q != 2'd3))
    else $error("Multiply phase out of sequence.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> (state_q == S_IDLE))
    else $error("Controller did not return to idle after a result.");

endmodule

// ===== rtl/lennard_jones_energy_engine_unit.sv =====
// Top level of the Lennard-Jones energy engine: handshakes, configuration registers,
// output register. Depends on lje_pkg, lje_store, lje_datapath and lje_ctrl.
//
// Usage: items enter on in_valid_i/in_stall_o, results leave on out_valid_o/out_stall_i.
// A write transaction stores a position and gives no result. A query gives
// the energy of a trial position against all particles in use but the excluded one; a
// total gives energy and virial over all pairs. Op code 3 is dropped.
// Pairs outside the cutoff or at zero separation skip the divider and multiplier; other
// pairs inside the cutoff run the one-bit-per-cycle divider and the 8-bit-digit multiplier.
// Input stall is high while an item runs.
// The next item is taken while a finished result waits in the output register; a new
// result waits in the controller until that register is free. Reset clears control
// state and restores the register defaults; the position store is undefined until written.
// Configuration writes are taken at any time but are meant for an idle block.
module lennard_jones_energy_engine_unit
  import lje_pkg::*;
#(
  parameter int unsigned MAX_PARTICLES = DEF_MAX_PARTICLES,
  parameter int unsigned FRACTION_BITS = DEF_FRACTION_BITS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_item_t         in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_item_t        out_data_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [1:0]       cfg_index_i,
  input  logic [CFG_W-1:0] cfg_data_i
);

  localparam int unsigned CW = $clog2(MAX_PARTICLES + 1);
  localparam int unsigned AW = $clog2(MAX_PARTICLES);

  logic [CFG_W-1:0] box_q, cut_q;
  logic [CNT_W-1:0] count_q;
  logic [CW-1:0] n_use;
  logic in_acc, start, wr_en, idle, done, out_free, rd_en;
  logic [AW-1:0] rd_addr;
  cmd_t cmd;
  status_t status;
  pos_t in_pos, mem_pos;
  out_item_t result;
  logic out_valid_q;
  out_item_t out_data_q;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o = !idle;
  assign in_acc = in_valid_i && idle;
  assign start = in_acc && (in_data_i.op == OP_QUERY || in_data_i.op == OP_TOTAL);
  assign wr_en = in_acc && (in_data_i.op == OP_WRITE)
                 && (32'(in_data_i.particle_index) < MAX_PARTICLES);
  assign n_use = (32'(count_q) > MAX_PARTICLES) ? CW'(MAX_PARTICLES) : CW'(count_q);
  assign in_pos = '{x: in_data_i.pos_x, y: in_data_i.pos_y, z: in_data_i.pos_z};
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_q <= BOX_RESET;
      cut_q <= CUT_RESET;
      count_q <= COUNT_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_BOX_LENGTH: box_q <= cfg_data_i;
        REG_CUTOFF_SQUARED: cut_q <= cfg_data_i;
        REG_PARTICLE_COUNT: count_q <= cfg_data_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (done) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o = out_data_q;

  lje_store #(
    .DEPTH(MAX_PARTICLES),
    .AW   (AW)
  ) u_store (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(AW'(in_data_i.particle_index)),
    .wr_data_i(in_pos),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(mem_pos)
  );

  lje_ctrl #(
    .MAX_PARTICLES(MAX_PARTICLES),
    .FRACTION_BITS(FRACTION_BITS),
    .CW           (CW),
    .AW           (AW)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .total_i   (in_data_i.op == OP_TOTAL),
    .excl_i    (in_data_i.particle_index),
    .n_i       (n_use),
    .status_i  (status),
    .out_free_i(out_free),
    .idle_o    (idle),
    .done_o    (done),
    .cmd_o     (cmd),
    .rd_en_o   (rd_en),
    .rd_addr_o (rd_addr)
  );

  lje_datapath #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .in_pos_i (in_pos),
    .mem_pos_i(mem_pos),
    .box_i    (box_q),
    .cut_i    (cut_q),
    .status_o (status),
    .result_o (result)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> out_valid_q && $stable(out_data_q))
    else $error("Stalled result transaction changed or vanished.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> out_free)
    else $error("Result loaded over an untaken result.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> idle)
    else $error("Position write outside idle.");

endmodule

// ===== sim/lennard_jones_energy_engine_unit_test.sv =====
// Testbench for lennard_jones_energy_engine_unit: directed rows, then random traffic
// checked against a fixed-point pair-energy predictor. Depends on lje_pkg and the RTL.
`timescale 1ns / 100ps

module lennard_jones_energy_engine_unit_test;
  import lje_pkg::*;

  localparam longint ONE = 65536;
  localparam longint SUM_HI = 64'sh7FFF_FFFF_FFFF;
  localparam longint SUM_LO = -SUM_HI - 1;
  localparam int DRAIN_CYCLES = 40;
  localparam longint CYCLE_LIMIT = 20_000_000;
  localparam int TARGET_ITEMS = 1550;

  typedef struct {
    bit is_cfg;
    reg_e reg_idx;
    logic [CFG_W-1:0] reg_val;
    in_item_t item;
    bit typed;
    out_item_t want;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  lennard_jones_energy_engine_unit u_top (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  longint mem_x[256];
  longint mem_y[256];
  longint mem_z[256];
  longint box_reg = 655360;
  longint cut_reg = 409600;
  longint count_reg = 256;

  out_item_t pending_results[$];
  stim_row_t stim_rows[$];
  int errors = 0;
  int send_idle = 0;
  int recv_idle = 0;
  int phase = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  longint cycles = 0;

  function automatic longint wrap_image(longint d);
    if (2 * d > box_reg) return d - box_reg;
    if (2 * d < -box_reg) return d + box_reg;
    return d;
  endfunction

  function automatic longint unsigned mul_cap(longint unsigned a, longint unsigned b,
                                              inout bit capped);
    longint unsigned p;
    if (a != 0 && b > 64'hFFFF_FFFF_FFFF_FFFF / a) begin
      capped = 1'b1;
      return SUM_HI;
    end
    p = (a * b) >> 16;
    if (p > SUM_HI) begin
      capped = 1'b1;
      return SUM_HI;
    end
    return p;
  endfunction

  function automatic longint sat_add(longint a, longint b, inout bit sat);
    longint r;
    r = a + b;
    if (r > SUM_HI) begin
      sat = 1'b1;
      return SUM_HI;
    end
    if (r < SUM_LO) begin
      sat = 1'b1;
      return SUM_LO;
    end
    return r;
  endfunction

  function automatic bit pair_energy(longint ax, longint ay, longint az, int j,
                                     output longint et, output longint wt, inout bit sat);
    longint dx, dy, dz;
    longint unsigned q, s, inv, i2, i3, i6;
    bit capped;
    capped = 1'b0;
    et = 0;
    wt = 0;
    dx = wrap_image(ax - mem_x[j]);
    dy = wrap_image(ay - mem_y[j]);
    dz = wrap_image(az - mem_z[j]);
    q = dx * dx + dy * dy + dz * dz;
    if (q >= (longint'(cut_reg) << 16)) return 1'b0;
    s = q >> 16;
    if (s == 0) begin
      capped = 1'b1;
      inv = SUM_HI;
    end else begin
      inv = (64'd1 << 32) / s;
      if (inv > SUM_HI) begin
        capped = 1'b1;
        inv = SUM_HI;
      end
    end
    i2 = mul_cap(inv, inv, capped);
    i3 = mul_cap(i2, inv, capped);
    i6 = mul_cap(i3, i3, capped);
    if (capped) begin
      sat = 1'b1;
      et = SUM_HI;
      wt = SUM_HI;
    end else begin
      et = longint'(i6) - longint'(i3);
      wt = longint'(i6) - longint'(i3 >> 1);
    end
    return 1'b1;
  endfunction

  function automatic bit predict_engine(in_item_t it, output out_item_t res);
    longint px, py, pz, esum, wsum, et, wt, energy, virial;
    int n;
    bit sat;
    px = $signed(it.pos_x);
    py = $signed(it.pos_y);
    pz = $signed(it.pos_z);
    n = (count_reg > 256) ? 256 : int'(count_reg);
    esum = 0;
    wsum = 0;
    sat = 1'b0;
    res = '0;
    if (it.op == OP_WRITE) begin
      mem_x[it.particle_index] = px;
      mem_y[it.particle_index] = py;
      mem_z[it.particle_index] = pz;
      return 1'b0;
    end else if (it.op == OP_QUERY) begin
      for (int j = 0; j < n; j++) begin
        if (j != it.particle_index && pair_energy(px, py, pz, j, et, wt, sat))
          esum = sat_add(esum, et, sat);
      end
      energy = sat_add(0, esum * 4, sat);
      virial = 0;
    end else if (it.op == OP_TOTAL) begin
      for (int i = 0; i + 1 < n; i++) begin
        for (int j = i + 1; j < n; j++) begin
          if (pair_energy(mem_x[i], mem_y[i], mem_z[i], j, et, wt, sat)) begin
            esum = sat_add(esum, et, sat);
            wsum = sat_add(wsum, wt, sat);
          end
        end
      end
      energy = sat_add(0, esum * 4, sat);
      virial = sat_add(0, wsum * 16, sat);
    end else begin
      return 1'b0;
    end
    res.energy = energy[47:0];
    res.virial = virial[47:0];
    res.saturated = sat;
    return 1'b1;
  endfunction

  function automatic in_item_t mk_item(logic [1:0] op, int idx, longint x, longint y,
                                       longint z);
    in_item_t it;
    it.op = op;
    it.particle_index = idx[7:0];
    it.pos_x = x[23:0];
    it.pos_y = y[23:0];
    it.pos_z = z[23:0];
    return it;
  endfunction

  function automatic void add_item(in_item_t it, bit typed = 1'b0, out_item_t want = '0);
    stim_row_t r;
    r.is_cfg = 1'b0;
    r.reg_idx = REG_BOX_LENGTH;
    r.reg_val = '0;
    r.item = it;
    r.typed = typed;
    r.want = want;
    stim_rows.push_back(r);
  endfunction

  function automatic void add_cfg(reg_e idx, longint val);
    stim_row_t r;
    r.is_cfg = 1'b1;
    r.reg_idx = idx;
    r.reg_val = val[CFG_W-1:0];
    r.item = '0;
    r.typed = 1'b0;
    r.want = '0;
    stim_rows.push_back(r);
  endfunction

  task automatic send_item(in_item_t it, bit typed, out_item_t want);
    out_item_t res;
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk_i); while (in_stall);
    if (predict_engine(it, res)) pending_results.push_back(typed ? want : res);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_e idx, logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk_i);
    case (idx)
      REG_BOX_LENGTH: box_reg = val;
      REG_CUTOFF_SQUARED: cut_reg = val;
      default: count_reg = val[CNT_W-1:0];
    endcase
  endtask

  function automatic longint rand_coord();
    longint half;
    half = box_reg / 2;
    if ($urandom_range(99) < 20 || half == 0) return $signed(24'($urandom()));
    return longint'($urandom_range(0, 2 * half)) - half;
  endfunction

  function automatic in_item_t rand_item(logic [1:0] op);
    return mk_item(op, $urandom_range(255), rand_coord(), rand_coord(), rand_coord());
  endfunction

  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
      if (hold_left == 1) hold_done <= 1'b1;
    end else if (phase == 3 && !hold_done) begin
      out_stall <= 1'b1;
      hold_left <= 40000;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle);
    end
  end

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result energy=%h virial=%h saturated=%b", $time,
                 out_data.energy, out_data.virial, out_data.saturated);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.energy !== want.energy) begin
          $display("%0t: energy expected %h actual %h", $time, want.energy,
                   out_data.energy);
          errors++;
        end
        if (out_data.virial !== want.virial) begin
          $display("%0t: virial expected %h actual %h", $time, want.virial,
                   out_data.virial);
          errors++;
        end
        if (out_data.saturated !== want.saturated) begin
          $display("%0t: saturated expected %b actual %b", $time, want.saturated,
                   out_data.saturated);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    out_item_t zero_res, cap_res;
    int items_sent, count_pick, n_sub;
    bit big;
    longint box_pick, cut_pick;
    int r;

    for (int i = 0; i < 256; i++) begin
      mem_x[i] = 0;
      mem_y[i] = 0;
      mem_z[i] = 0;
    end
    zero_res = '0;
    cap_res = '0;
    cap_res.energy = SUM_HI[47:0];
    cap_res.saturated = 1'b1;

    add_cfg(REG_PARTICLE_COUNT, 2);
    add_item(mk_item(OP_WRITE, 0, 0, 0, 0));
    add_item(mk_item(OP_WRITE, 1, ONE, 0, 0));
    add_item(mk_item(OP_QUERY, 1, 0, 0, 0), 1'b1, cap_res);
    add_item(mk_item(OP_QUERY, 0, 0, 0, 0), 1'b1, zero_res);
    add_item(mk_item(OP_QUERY, 200, 0, 0, 0));
    add_item(mk_item(OP_TOTAL, 0, 0, 0, 0));
    add_item(mk_item(2'd3, 255, -1, -1, -1));
    add_item(mk_item(OP_WRITE, 2, 8388607, 8388607, 8388607));
    add_item(mk_item(OP_WRITE, 3, -8388608, -8388608, -8388608));
    add_item(mk_item(OP_WRITE, 255, -8388608, 8388607, 0));
    add_cfg(REG_PARTICLE_COUNT, 4);
    add_item(mk_item(OP_QUERY, 3, 8388607, -8388608, ONE / 2));
    add_item(mk_item(OP_TOTAL, 0, 0, 0, 0));
    add_cfg(REG_BOX_LENGTH, 0);
    add_item(mk_item(OP_QUERY, 255, ONE / 4, 0, 0));
    add_cfg(REG_BOX_LENGTH, 8388607);
    add_cfg(REG_CUTOFF_SQUARED, 0);
    add_item(mk_item(OP_TOTAL, 0, 0, 0, 0), 1'b1, zero_res);
    add_cfg(REG_CUTOFF_SQUARED, 8388607);
    add_item(mk_item(OP_TOTAL, 0, 0, 0, 0));
    add_cfg(REG_PARTICLE_COUNT, 0);
    add_item(mk_item(OP_TOTAL, 0, 0, 0, 0), 1'b1, zero_res);
    add_item(mk_item(OP_QUERY, 0, 0, 0, 0), 1'b1, zero_res);
    add_cfg(REG_PARTICLE_COUNT, 1);
    add_item(mk_item(OP_TOTAL, 0, 0, 0, 0), 1'b1, zero_res);
    add_cfg(REG_BOX_LENGTH, 655360);
    add_cfg(REG_CUTOFF_SQUARED, 409600);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    items_sent = 0;
    foreach (stim_rows[k]) begin
      if (stim_rows[k].is_cfg) begin
        drain();
        write_reg(stim_rows[k].reg_idx, stim_rows[k].reg_val);
      end else begin
        send_item(stim_rows[k].item, stim_rows[k].typed, stim_rows[k].want);
        items_sent++;
      end
    end

    // Every slot is written before any count above the directed ones is used.
    for (int i = 0; i < 256; i++) begin
      send_item(mk_item(OP_WRITE, i, rand_coord(), rand_coord(), rand_coord()), 1'b0,
                zero_res);
      items_sent++;
    end

    for (int p = 1; p <= 3; p++) begin
      send_idle = (p == 1) ? 31 : (p == 2) ? 85 : 0;
      recv_idle = (p == 1) ? 85 : (p == 2) ? 31 : 0;
      while (items_sent < 276 + p * (TARGET_ITEMS - 276) / 3) begin
        drain();
        phase = p;
        r = $urandom_range(9);
        box_pick = (r == 0) ? 0 : (r == 1) ? 8388607 : $urandom_range(2 * ONE, 12 * ONE);
        r = $urandom_range(9);
        cut_pick = (r == 0) ? 0 : (r == 1) ? 8388607 : $urandom_range(ONE, 16 * ONE);
        r = $urandom_range(19);
        count_pick = (r == 0) ? 0 : (r == 1) ? 1 : (r == 2) ? 256 :
                     (r == 3) ? $urandom_range(257, 511) : $urandom_range(2, 10);
        write_reg(REG_BOX_LENGTH, box_pick[CFG_W-1:0]);
        write_reg(REG_CUTOFF_SQUARED, cut_pick[CFG_W-1:0]);
        write_reg(REG_PARTICLE_COUNT, count_pick[CFG_W-1:0]);
        big = count_pick > 16;
        n_sub = big ? 4 : 30;
        for (int k = 0; k < n_sub; k++) begin
          r = $urandom_range(99);
          if (r < 35) begin
            send_item(rand_item(OP_WRITE), 1'b0, zero_res);
          end else if (r < 85 || (big && r < 97)) begin
            send_item(rand_item(OP_QUERY), 1'b0, zero_res);
          end else if (r < 97) begin
            send_item(rand_item(OP_TOTAL), 1'b0, zero_res);
          end else begin
            send_item(rand_item(2'd3), 1'b0, zero_res);
            continue;
          end
          items_sent++;
        end
      end
    end

    drain();
    repeat (100) @(posedge clk_i);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
